// ----- rtl/buddy_page_allocator_unit_assert.svh -----
// ------------------------------------------------------------------------
// buddy page allocator assertion macros
// shared property forms for the allocator checker
// ------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_UNIT_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define BPA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("buddy allocator assertion failed");

// next-cycle implication
`define BPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("buddy allocator assertion failed");

`endif

// ----- rtl/bpa_pkg.sv -----
// ------------------------------------------------------------------------
// bpa_pkg
// shared types and codes of the buddy page allocator
// ------------------------------------------------------------------------
package bpa_pkg;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NOFREE   = 2'd1,
        STAT_MISALIGN = 2'd2,
        STAT_RANGE    = 2'd3
    } status_t;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic LINK_NEXT = 1'b0;
    localparam logic LINK_PREV = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ASRCH,
        S_UNL_N,
        S_UNL_P,
        S_UNL_W1,
        S_UNL_W2,
        S_TGL_R,
        S_TGL_W,
        S_SPLIT,
        S_MERGE,
        S_PUSH1,
        S_PUSH2,
        S_PUSH3,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_GRAB,
        PH_SPLIT,
        PH_MERGE,
        PH_FINAL
    } phase_t;

endpackage

// ----- rtl/bpa_req_if.sv -----
// ------------------------------------------------------------------------
// bpa_req_if
// request channel: allocate or free word
// ------------------------------------------------------------------------
interface bpa_req_if #(
    parameter int OW = 4,
    parameter int PW = 10
);
    logic          valid;
    logic          ready;
    logic          req_type;
    logic [OW-1:0] block_order;
    logic [PW-1:0] page_index;

    modport source (output valid, output req_type, output block_order, output page_index,
                    input ready);
    modport sink (input valid, input req_type, input block_order, input page_index,
                  output ready);
endinterface

// ----- rtl/bpa_rsp_if.sv -----
// ------------------------------------------------------------------------
// bpa_rsp_if
// result channel: one word per request
// ------------------------------------------------------------------------
interface bpa_rsp_if #(
    parameter int PW = 10,
    parameter int CW = 11
);
    logic          valid;
    logic          ready;
    logic [1:0]    status;
    logic [PW-1:0] granted_page;
    logic [CW-1:0] free_total;

    modport source (output valid, output status, output granted_page, output free_total,
                    input ready);
    modport sink (input valid, input status, input granted_page, input free_total,
                  output ready);
endinterface

// ----- rtl/bpa_cfg_if.sv -----
// ------------------------------------------------------------------------
// bpa_cfg_if
// configuration write channel for the zone size
// ------------------------------------------------------------------------
interface bpa_cfg_if #(
    parameter int CW = 11
);
    logic          valid;
    logic          ready;
    logic [CW-1:0] zone_pages;

    modport source (output valid, output zone_pages, input ready);
    modport sink (input valid, input zone_pages, output ready);
endinterface

// ----- rtl/buddy_page_allocator_unit.sv -----
// One request is in flight at a time.
// The link memory has a single read and a single write port.
// Reset: pair bits are cleared one entry a cycle, all PAGE_COUNT + ORDER_COUNT entries
//   (1034 by default), before the first request is taken; configuration is taken at once.
// ------------------------------------------------------------------------
// buddy_page_allocator_unit
// binary buddy allocator over linked free lists kept in ram
// ------------------------------------------------------------------------
module buddy_page_allocator_unit #(
    parameter int PAGE_COUNT  = 1024,
    parameter int ORDER_COUNT = 10
) (
    input  logic  clk,
    input  logic  rst_n,
    bpa_req_if.sink   req,
    bpa_rsp_if.source rsp,
    bpa_cfg_if.sink   cfg
);
    localparam int PW         = $clog2(PAGE_COUNT);
    localparam int CW         = PW + 1;
    localparam int OW         = $clog2(ORDER_COUNT + 1);
    localparam int OIW        = (ORDER_COUNT > 1) ? $clog2(ORDER_COUNT) : 1;
    localparam int SW         = ((CW > ORDER_COUNT) ? CW : ORDER_COUNT) + 1;
    localparam int PAIR_SLOTS = PAGE_COUNT + ORDER_COUNT;
    localparam int PAW        = $clog2(PAIR_SLOTS);
    localparam int LAW        = PW + 1;
    localparam logic [CW-1:0] NONE = CW'(PAGE_COUNT);

    function automatic int pair_base_f(input int o);
        int b;
        b = 0;
        for (int k = 0; k < o; k++)
        begin
            b += ((PAGE_COUNT - 1) >> (k + 1)) + 1;
        end
        return b;
    endfunction

    logic [PAW:0] pair_base [ORDER_COUNT];

    for (genvar g = 0; g < ORDER_COUNT; g++)
    begin : g_base
        assign pair_base[g] = (PAW + 1)'(pair_base_f(g));
    end

    bpa_pkg::state_t  state_reg, state_next;
    bpa_pkg::phase_t  phase_reg, phase_next;
    bpa_pkg::status_t rstat_reg, rstat_next;
    bpa_pkg::status_t ostat_reg, ostat_next;
    logic [OW-1:0]  ord_reg, ord_next;
    logic [OW-1:0]  co_reg, co_next;
    logic [PW-1:0]  page_reg, page_next;
    logic [PW-1:0]  tgt_reg, tgt_next;
    logic [CW-1:0]  nx_reg, nx_next;
    logic [CW-1:0]  pv_reg, pv_next;
    logic [CW-1:0]  fc_reg, fc_next;
    logic [CW-1:0]  zone_reg, zone_next;
    logic [CW-1:0]  head_reg [ORDER_COUNT];
    logic [CW-1:0]  head_next [ORDER_COUNT];
    logic [PAW-1:0] clr_reg, clr_next;
    logic [PAW-1:0] paddr_reg, paddr_next;
    logic           pvalid_reg, pvalid_next;
    logic [PW-1:0]  rgrant_reg, rgrant_next;
    logic           ovalid_reg, ovalid_next;
    logic [PW-1:0]  ogrant_reg, ogrant_next;
    logic [CW-1:0]  ofree_reg, ofree_next;

    logic           link_we;
    logic [LAW-1:0] link_waddr;
    logic [CW-1:0]  link_wdata;
    logic [LAW-1:0] link_raddr;
    logic [CW-1:0]  link_rdata;
    logic           pair_we;
    logic [PAW-1:0] pair_waddr;
    logic           pair_wdata;
    logic [PAW-1:0] pair_raddr;
    logic           pair_rdata;

    logic [SW-1:0]  in_size;
    logic [SW-1:0]  ord_size;
    logic [SW-1:0]  co_size;
    logic [SW-1:0]  fc_sum;
    logic [CW-1:0]  bound;
    logic [OIW-1:0] co_idx;
    logic [CW-1:0]  head_cur;
    logic [PAW:0]   paddr_sum;
    logic           tgl_old;

    bpa_ram #(.WIDTH(CW), .DEPTH(2 * PAGE_COUNT)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    bpa_ram #(.WIDTH(1), .DEPTH(PAIR_SLOTS)) u_pair_ram (
        .clk   (clk),
        .we    (pair_we),
        .waddr (pair_waddr),
        .wdata (pair_wdata),
        .raddr (pair_raddr),
        .rdata (pair_rdata)
    );

    assign in_size   = SW'(1) << req.block_order;
    assign ord_size  = SW'(1) << ord_reg;
    assign co_size   = SW'(1) << co_reg;
    assign fc_sum    = SW'(fc_reg) + in_size;
    assign bound     = (zone_reg < NONE) ? zone_reg : NONE;
    assign co_idx    = co_reg[OIW-1:0];
    assign head_cur  = head_reg[co_idx];
    assign paddr_sum = pair_base[co_idx] + (PAW + 1)'((page_reg >> co_reg) >> 1);
    assign tgl_old   = pvalid_reg & pair_rdata;

    assign req.ready        = (state_reg == bpa_pkg::S_IDLE);
    assign cfg.ready        = 1'b1;
    assign rsp.valid        = ovalid_reg;
    assign rsp.status       = ostat_reg;
    assign rsp.granted_page = ogrant_reg;
    assign rsp.free_total   = ofree_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bpa_pkg::S_CLEAR;
            phase_reg  <= bpa_pkg::PH_GRAB;
            fc_reg     <= '0;
            zone_reg   <= CW'(PAGE_COUNT);
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < ORDER_COUNT; i++)
            begin
                head_reg[i] <= NONE;
            end
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            fc_reg     <= fc_next;
            zone_reg   <= zone_next;
            clr_reg    <= clr_next;
            ovalid_reg <= ovalid_next;
            head_reg   <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rstat_reg  <= rstat_next;
        ostat_reg  <= ostat_next;
        ord_reg    <= ord_next;
        co_reg     <= co_next;
        page_reg   <= page_next;
        tgt_reg    <= tgt_next;
        nx_reg     <= nx_next;
        pv_reg     <= pv_next;
        paddr_reg  <= paddr_next;
        pvalid_reg <= pvalid_next;
        rgrant_reg <= rgrant_next;
        ogrant_reg <= ogrant_next;
        ofree_reg  <= ofree_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        rstat_next  = rstat_reg;
        ostat_next  = ostat_reg;
        ord_next    = ord_reg;
        co_next     = co_reg;
        page_next   = page_reg;
        tgt_next    = tgt_reg;
        nx_next     = nx_reg;
        pv_next     = pv_reg;
        fc_next     = fc_reg;
        zone_next   = zone_reg;
        head_next   = head_reg;
        clr_next    = clr_reg;
        paddr_next  = paddr_reg;
        pvalid_next = pvalid_reg;
        rgrant_next = rgrant_reg;
        ovalid_next = ovalid_reg;
        ogrant_next = ogrant_reg;
        ofree_next  = ofree_reg;
        link_we     = 1'b0;
        link_waddr  = '0;
        link_wdata  = '0;
        link_raddr  = '0;
        pair_we     = 1'b0;
        pair_waddr  = paddr_reg;
        pair_wdata  = 1'b0;
        pair_raddr  = paddr_sum[PAW-1:0];

        if (cfg.valid)
        begin
            zone_next = cfg.zone_pages;
        end
        if (ovalid_reg && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            bpa_pkg::S_CLEAR:
            begin
                pair_we    = 1'b1;
                pair_waddr = clr_reg;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == PAW'(PAIR_SLOTS - 1))
                begin
                    state_next = bpa_pkg::S_IDLE;
                end
            end
            bpa_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    ord_next    = req.block_order;
                    co_next     = req.block_order;
                    page_next   = req.page_index;
                    rgrant_next = '0;
                    state_next  = bpa_pkg::S_DONE;
                    if (req.req_type == bpa_pkg::REQ_ALLOC)
                    begin
                        if (req.block_order >= OW'(ORDER_COUNT))
                        begin
                            rstat_next = bpa_pkg::STAT_NOFREE;
                        end
                        else
                        begin
                            state_next = bpa_pkg::S_ASRCH;
                        end
                    end
                    else if (req.block_order >= OW'(ORDER_COUNT))
                    begin
                        rstat_next = bpa_pkg::STAT_RANGE;
                    end
                    else if ((SW'(req.page_index) & (in_size - 1'b1)) != '0)
                    begin
                        rstat_next = bpa_pkg::STAT_MISALIGN;
                    end
                    else if ((SW'(req.page_index) + in_size) > SW'(bound))
                    begin
                        rstat_next = bpa_pkg::STAT_RANGE;
                    end
                    else
                    begin
                        rstat_next = bpa_pkg::STAT_OK;
                        fc_next    = (fc_sum > SW'(NONE)) ? NONE : fc_sum[CW-1:0];
                        phase_next = bpa_pkg::PH_MERGE;
                        state_next = bpa_pkg::S_MERGE;
                    end
                end
            end
            bpa_pkg::S_ASRCH:
            begin
                if (co_reg >= OW'(ORDER_COUNT))
                begin
                    rstat_next = bpa_pkg::STAT_NOFREE;
                    state_next = bpa_pkg::S_DONE;
                end
                else if (head_cur >= NONE)
                begin
                    co_next = co_reg + 1'b1;
                end
                else
                begin
                    page_next  = head_cur[PW-1:0];
                    tgt_next   = head_cur[PW-1:0];
                    phase_next = bpa_pkg::PH_GRAB;
                    state_next = bpa_pkg::S_UNL_N;
                end
            end
            bpa_pkg::S_UNL_N:
            begin
                link_raddr = {bpa_pkg::LINK_NEXT, tgt_reg};
                if (CW'(tgt_reg) < NONE)
                begin
                    state_next = bpa_pkg::S_UNL_P;
                end
                else
                begin
                    nx_next    = NONE;
                    state_next = bpa_pkg::S_UNL_W2;
                end
            end
            bpa_pkg::S_UNL_P:
            begin
                link_raddr = {bpa_pkg::LINK_PREV, tgt_reg};
                nx_next    = (link_rdata > NONE) ? NONE : link_rdata;
                state_next = bpa_pkg::S_UNL_W1;
            end
            bpa_pkg::S_UNL_W1:
            begin
                if (link_rdata < NONE)
                begin
                    link_we    = 1'b1;
                    link_waddr = {bpa_pkg::LINK_NEXT, link_rdata[PW-1:0]};
                    link_wdata = nx_reg;
                    pv_next    = link_rdata;
                end
                else
                begin
                    head_next[co_idx] = nx_reg;
                    pv_next           = NONE;
                end
                state_next = bpa_pkg::S_UNL_W2;
            end
            bpa_pkg::S_UNL_W2:
            begin
                if (nx_reg < NONE)
                begin
                    link_we    = 1'b1;
                    link_waddr = {bpa_pkg::LINK_PREV, nx_reg[PW-1:0]};
                    link_wdata = pv_reg;
                end
                if (phase_reg == bpa_pkg::PH_MERGE)
                begin
                    co_next    = co_reg + 1'b1;
                    page_next  = page_reg & ~PW'((co_size << 1) - 1'b1);
                    state_next = bpa_pkg::S_MERGE;
                end
                else
                begin
                    state_next = bpa_pkg::S_TGL_R;
                end
            end
            bpa_pkg::S_TGL_R:
            begin
                paddr_next  = paddr_sum[PAW-1:0];
                pvalid_next = paddr_sum < (PAW + 1)'(PAIR_SLOTS);
                state_next  = bpa_pkg::S_TGL_W;
            end
            bpa_pkg::S_TGL_W:
            begin
                pair_we    = pvalid_reg;
                pair_wdata = ~pair_rdata;
                case (phase_reg)
                    bpa_pkg::PH_GRAB:
                    begin
                        fc_next    = (SW'(fc_reg) >= ord_size) ?
                                     CW'(SW'(fc_reg) - ord_size) : '0;
                        state_next = bpa_pkg::S_SPLIT;
                    end
                    bpa_pkg::PH_SPLIT:
                    begin
                        page_next  = page_reg + PW'(co_size);
                        state_next = bpa_pkg::S_SPLIT;
                    end
                    bpa_pkg::PH_MERGE:
                    begin
                        if (tgl_old)
                        begin
                            tgt_next   = page_reg ^ PW'(co_size);
                            state_next = bpa_pkg::S_UNL_N;
                        end
                        else
                        begin
                            phase_next = bpa_pkg::PH_FINAL;
                            state_next = bpa_pkg::S_PUSH1;
                        end
                    end
                    default:
                    begin
                        state_next = bpa_pkg::S_PUSH1;
                    end
                endcase
            end
            bpa_pkg::S_SPLIT:
            begin
                if (co_reg > ord_reg)
                begin
                    co_next    = co_reg - 1'b1;
                    phase_next = bpa_pkg::PH_SPLIT;
                    state_next = bpa_pkg::S_PUSH1;
                end
                else
                begin
                    rstat_next  = bpa_pkg::STAT_OK;
                    rgrant_next = page_reg;
                    state_next  = bpa_pkg::S_DONE;
                end
            end
            bpa_pkg::S_MERGE:
            begin
                if ((co_reg + 1'b1) < OW'(ORDER_COUNT))
                begin
                    state_next = bpa_pkg::S_TGL_R;
                end
                else
                begin
                    phase_next = bpa_pkg::PH_FINAL;
                    state_next = bpa_pkg::S_PUSH1;
                end
            end
            bpa_pkg::S_PUSH1:
            begin
                link_we    = CW'(page_reg) < NONE;
                link_waddr = {bpa_pkg::LINK_NEXT, page_reg};
                link_wdata = head_cur;
                state_next = bpa_pkg::S_PUSH2;
            end
            bpa_pkg::S_PUSH2:
            begin
                link_we    = CW'(page_reg) < NONE;
                link_waddr = {bpa_pkg::LINK_PREV, page_reg};
                link_wdata = NONE;
                state_next = bpa_pkg::S_PUSH3;
            end
            bpa_pkg::S_PUSH3:
            begin
                if (CW'(page_reg) < NONE)
                begin
                    link_we           = head_cur < NONE;
                    link_waddr        = {bpa_pkg::LINK_PREV, head_cur[PW-1:0]};
                    link_wdata        = CW'(page_reg);
                    head_next[co_idx] = CW'(page_reg);
                end
                if (phase_reg == bpa_pkg::PH_SPLIT)
                begin
                    state_next = bpa_pkg::S_TGL_R;
                end
                else
                begin
                    rstat_next  = bpa_pkg::STAT_OK;
                    rgrant_next = '0;
                    state_next  = bpa_pkg::S_DONE;
                end
            end
            bpa_pkg::S_DONE:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = rstat_reg;
                    ogrant_next = rgrant_reg;
                    ofree_next  = fc_reg;
                    state_next  = bpa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bpa_pkg::S_IDLE;
            end
        endcase
    end
endmodule

// ----- rtl/bpa_ram.sv -----
// ------------------------------------------------------------------------
// bpa_ram
// generic single write, single read ram with registered read
// ------------------------------------------------------------------------
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- rtl/bpa_checker.sv -----
// ------------------------------------------------------------------------
// bpa_checker
// port level checks of the buddy page allocator
// ------------------------------------------------------------------------
`include "buddy_page_allocator_unit_assert.svh"

module bpa_checker #(
    parameter int PAGE_COUNT = 1024
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [1:0]                      status,
    input logic [$clog2(PAGE_COUNT)-1:0]   granted_page,
    input logic [$clog2(PAGE_COUNT):0]     free_total
);
    localparam int CW = $clog2(PAGE_COUNT) + 1;

    // one request in flight
    `BPA_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)
    // stalled word stays
    `BPA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    // failed requests grant nothing
    `BPA_ASSERT_IMPLY(a_fail_no_grant, clk, rst_n, out_valid && (status != bpa_pkg::STAT_OK), granted_page == '0)
    // free count never exceeds PAGE_COUNT
    `BPA_ASSERT_IMPLY(a_free_bound, clk, rst_n, out_valid, free_total <= CW'(PAGE_COUNT))
endmodule

bind buddy_page_allocator_unit bpa_checker #(.PAGE_COUNT(PAGE_COUNT)) u_bpa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (req.valid),
    .in_ready     (req.ready),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .status       (rsp.status),
    .granted_page (rsp.granted_page),
    .free_total   (rsp.free_total)
);

// ----- tb/tb_buddy_page_allocator_unit.sv -----
// ------------------------------------------------------------------------
// tb_buddy_page_allocator_unit
// self-checking bench for the buddy page allocator: a local allocator model
// predicts each result word, well-formed alloc/free traffic with random
// gaps, stalls and zone sizes, plus rejected requests as noise
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_buddy_page_allocator_unit;

    localparam int PAGES     = 1024;
    localparam int ORDERS    = 10;
    localparam int NONE      = PAGES;
    localparam int LIMIT     = 800000;
    localparam int SETTLE    = 100;

    typedef struct {
        bpa_pkg::status_t st;
        logic [9:0]       page;
        logic [10:0]      total;
    } rsp_word_t;

    typedef struct {
        int unsigned page;
        int unsigned order;
    } block_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bpa_req_if req_ch ();
    bpa_rsp_if rsp_ch ();
    bpa_cfg_if cfg_ch ();

    buddy_page_allocator_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // allocator state mirror
    int unsigned next_pg [PAGES];
    int unsigned prev_pg [PAGES];
    int unsigned head_pg [ORDERS];
    bit          pair_st [PAGES + ORDERS];
    int unsigned pages_free;
    int unsigned zone_lim;

    // page ownership as seen by the bench, used to keep frees well formed
    bit          page_free [PAGES];
    bit          page_held [PAGES];
    block_t      held_blocks[$];

    rsp_word_t   pending_rsp[$];
    int          errors = 0;
    int          words_seen = 0;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_left = 0;
    int          n_alloc_ok = 0;
    int          n_free_ok = 0;
    int          n_reject = 0;

    function automatic bit flip_pair(int unsigned o, int unsigned p);
        int unsigned base;
        int unsigned addr;
        bit          old;
        base = 0;
        for (int unsigned k = 0; k < o; k++)
            base += ((PAGES - 1) >> (k + 1)) + 1;
        addr = base + (p >> (o + 1));
        if (addr >= PAGES + ORDERS)
            return 1'b0;
        old = pair_st[addr];
        pair_st[addr] = !old;
        return old;
    endfunction

    function automatic void push_blk(int unsigned o, int unsigned p);
        int unsigned h;
        h = head_pg[o];
        if (p >= NONE)
            return;
        next_pg[p] = h;
        prev_pg[p] = NONE;
        if (h < NONE)
            prev_pg[h] = p;
        head_pg[o] = p;
    endfunction

    function automatic void unlink_blk(int unsigned o, int unsigned p);
        int unsigned n;
        int unsigned pv;
        if (p >= NONE)
            return;
        n = next_pg[p];
        pv = prev_pg[p];
        if (n > NONE)
            n = NONE;
        if (pv < NONE)
            next_pg[pv] = n;
        else
            head_pg[o] = n;
        if (n < NONE)
            prev_pg[n] = (pv < NONE) ? pv : NONE;
    endfunction

    function automatic rsp_word_t allocator_step(logic kind, int unsigned ord, int unsigned pg);
        rsp_word_t   w;
        int unsigned co;
        int unsigned p;
        int unsigned o;
        int unsigned bound;
        bit          found;
        w.st = bpa_pkg::STAT_OK;
        w.page = '0;
        if (kind == bpa_pkg::REQ_ALLOC) begin
            w.st = bpa_pkg::STAT_NOFREE;
            found = 1'b0;
            if (ord < ORDERS) begin
                for (co = ord; co < ORDERS && !found; co++) begin
                    p = head_pg[co];
                    if (p < NONE) begin
                        found = 1'b1;
                        unlink_blk(co, p);
                        void'(flip_pair(co, p));
                        pages_free = (pages_free >= (1 << ord)) ? pages_free - (1 << ord) : 0;
                        while (co > ord) begin
                            co--;
                            push_blk(co, p);
                            void'(flip_pair(co, p));
                            p += 1 << co;
                        end
                        w.page = p[9:0];
                        w.st = bpa_pkg::STAT_OK;
                    end
                end
            end
        end else begin
            bound = (zone_lim < PAGES) ? zone_lim : PAGES;
            if (ord >= ORDERS)
                w.st = bpa_pkg::STAT_RANGE;
            else if ((pg & ((1 << ord) - 1)) != 0)
                w.st = bpa_pkg::STAT_MISALIGN;
            else if (pg + (1 << ord) > bound)
                w.st = bpa_pkg::STAT_RANGE;
            else begin
                o = ord;
                pages_free += 1 << ord;
                if (pages_free > PAGES)
                    pages_free = PAGES;
                while (o + 1 < ORDERS) begin
                    if (!flip_pair(o, pg))
                        break;
                    unlink_blk(o, pg ^ (1 << o));
                    o++;
                    pg &= ~((1 << o) - 1);
                end
                push_blk(o, pg);
            end
        end
        w.total = pages_free[10:0];
        return w;
    endfunction

    task automatic send_req(input logic kind, input int unsigned ord, input int unsigned pg,
                            output bpa_pkg::status_t st);
        int        gap;
        rsp_word_t w;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40)
            gap++;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= kind;
        req_ch.block_order <= ord[3:0];
        req_ch.page_index  <= pg[9:0];
        do
            @(posedge clk);
        while (!req_ch.ready);
        w = allocator_step(kind, ord & 15, pg & 1023);
        pending_rsp.push_back(w);
        st = w.st;
        if (w.st != bpa_pkg::STAT_OK)
            n_reject++;
        else if (kind == bpa_pkg::REQ_ALLOC)
        begin
            n_alloc_ok++;
            for (int i = 0; i < (1 << ord); i++)
            begin
                page_free[w.page + i] = 1'b0;
                page_held[w.page + i] = 1'b1;
            end
            held_blocks.push_back('{page: w.page, order: ord});
        end
        else
        begin
            n_free_ok++;
            for (int i = 0; i < (1 << ord); i++)
            begin
                page_free[pg + i] = 1'b1;
                page_held[pg + i] = 1'b0;
            end
        end
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_zone(input int unsigned v);
        wait_drained();
        cfg_ch.valid      <= 1'b1;
        cfg_ch.zone_pages <= v[10:0];
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        zone_lim = v & 11'h7FF;
    endtask

    // returns a block whose pages belong to nobody, or order 99 if none found
    function automatic block_t pick_fresh();
        block_t b;
        bit     clean;
        for (int t = 0; t < 8; t++)
        begin
            b.order = ($urandom_range(99) < 70) ? $urandom_range(0, 3) : $urandom_range(0, 9);
            b.page = $urandom_range(0, 1023) & ~((1 << b.order) - 1);
            clean = 1'b1;
            for (int i = 0; i < (1 << b.order); i++)
                if (page_free[b.page + i] || page_held[b.page + i])
                    clean = 1'b0;
            if (clean)
                return b;
        end
        b.order = 99;
        return b;
    endfunction

    task automatic random_request();
        int               r;
        int               idx;
        int unsigned      o;
        int unsigned      p;
        block_t           b;
        bpa_pkg::status_t st;
        r = $urandom_range(99);
        if (r < 45)
        begin
            r = $urandom_range(99);
            o = (r < 80) ? $urandom_range(0, 3) : (r < 97) ? $urandom_range(0, 9)
                                                            : $urandom_range(10, 15);
            send_req(bpa_pkg::REQ_ALLOC, o, $urandom_range(0, 1023), st);
        end
        else if (r < 80 && held_blocks.size() != 0)
        begin
            idx = $urandom_range(0, held_blocks.size() - 1);
            b = held_blocks[idx];
            send_req(bpa_pkg::REQ_FREE, b.order, b.page, st);
            if (st == bpa_pkg::STAT_OK)
                held_blocks.delete(idx);
        end
        else if (r < 90)
        begin
            b = pick_fresh();
            if (b.order != 99)
                send_req(bpa_pkg::REQ_FREE, b.order, b.page, st);
            else
                send_req(bpa_pkg::REQ_FREE, $urandom_range(10, 15), $urandom_range(0, 1023),
                         st);
        end
        else
        begin
            o = $urandom_range(0, 15);
            p = $urandom_range(0, 1023);
            case ($urandom_range(0, 2))
                0: send_req(bpa_pkg::REQ_ALLOC, $urandom_range(10, 15), p, st);
                1:
                begin
                    if (o >= ORDERS || o == 0)
                        send_req(bpa_pkg::REQ_FREE, $urandom_range(10, 15), p, st);
                    else
                    begin
                        if ((p & ((1 << o) - 1)) == 0)
                            p |= 1;
                        send_req(bpa_pkg::REQ_FREE, o, p, st);
                    end
                end
                default:
                begin
                    o = o % ORDERS;
                    p = p & ~((1 << o) - 1);
                    if (p + (1 << o) > ((zone_lim < PAGES) ? zone_lim : PAGES))
                        send_req(bpa_pkg::REQ_FREE, o, p, st);
                    else
                        send_req(bpa_pkg::REQ_FREE, $urandom_range(10, 15), p, st);
                end
            endcase
        end
    endtask

    task automatic run_phase(input int n, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) random_request();
    endtask

    task automatic test_directed();
        bpa_pkg::status_t st;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_req(bpa_pkg::REQ_ALLOC, 0, 0, st);
        send_req(bpa_pkg::REQ_ALLOC, 9, 1023, st);
        send_req(bpa_pkg::REQ_ALLOC, 10, 0, st);
        send_req(bpa_pkg::REQ_ALLOC, 15, 1023, st);
        send_req(bpa_pkg::REQ_FREE, 10, 0, st);
        send_req(bpa_pkg::REQ_FREE, 15, 1023, st);
        send_req(bpa_pkg::REQ_FREE, 3, 5, st);
        send_req(bpa_pkg::REQ_FREE, 9, 256, st);
        send_req(bpa_pkg::REQ_FREE, 9, 512, st);
        send_req(bpa_pkg::REQ_FREE, 0, 0, st);
        send_req(bpa_pkg::REQ_FREE, 0, 1, st);
        send_req(bpa_pkg::REQ_FREE, 1, 2, st);
        send_req(bpa_pkg::REQ_FREE, 2, 4, st);
        send_req(bpa_pkg::REQ_ALLOC, 0, 1023, st);
        send_req(bpa_pkg::REQ_ALLOC, 9, 0, st);
        send_req(bpa_pkg::REQ_ALLOC, 3, 0, st);
        send_req(bpa_pkg::REQ_ALLOC, 9, 0, st);
        send_req(bpa_pkg::REQ_FREE, 0, 8, st);
    endtask

    task automatic test_zone_limits();
        bpa_pkg::status_t st;
        write_zone(0);
        send_req(bpa_pkg::REQ_FREE, 0, 100, st);
        send_req(bpa_pkg::REQ_FREE, 0, 0, st);
        write_zone(1);
        send_req(bpa_pkg::REQ_FREE, 0, 1, st);
        send_req(bpa_pkg::REQ_FREE, 1, 0, st);
        write_zone(2047);
        send_req(bpa_pkg::REQ_FREE, 8, 256, st);
        run_phase(40, 20, 20);
        write_zone(1024);
    endtask

    task automatic test_open_flow();
        write_zone(1024);
        run_phase(350, 0, 0);
    endtask

    task automatic test_sender_gaps();
        write_zone($urandom_range(300, 1023));
        run_phase(250, 59, 0);
    endtask

    task automatic test_receiver_stalls();
        write_zone(2047);
        run_phase(250, 0, 59);
    endtask

    task automatic test_both_idle();
        write_zone(1024);
        run_phase(250, 20, 20);
    endtask

    task automatic test_backpressure();
        recv_stall_pct = 0;
        send_idle_pct = 0;
        hold_left = 400;
        repeat (6) random_request();
        while (hold_left != 0)
            @(posedge clk);
        run_phase(30, 0, 0);
    endtask

    task automatic test_drain_pause();
        run_phase(60, 20, 20);
        wait_drained();
        run_phase(60, 0, 0);
    endtask

    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        rsp_word_t w;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            words_seen++;
            if (pending_rsp.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: status %0d page %0d total %0d",
                             rsp_ch.status, rsp_ch.granted_page, rsp_ch.free_total);
            end
            else
            begin
                w = pending_rsp.pop_front();
                if (rsp_ch.status !== w.st || rsp_ch.granted_page !== w.page ||
                    rsp_ch.free_total !== w.total)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch at word %0d: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 words_seen, w.st, w.page, w.total, rsp_ch.status,
                                 rsp_ch.granted_page, rsp_ch.free_total);
                end
            end
        end
        if (hold_left > 0)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        req_ch.valid       = 1'b0;
        req_ch.req_type    = bpa_pkg::REQ_ALLOC;
        req_ch.block_order = '0;
        req_ch.page_index  = '0;
        rsp_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.zone_pages  = 11'd1024;
        for (int i = 0; i < ORDERS; i++)
            head_pg[i] = NONE;
        for (int i = 0; i < PAGES + ORDERS; i++)
            pair_st[i] = 1'b0;
        pages_free = 0;
        zone_lim = 1024;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_zone_limits();
        test_open_flow();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        test_backpressure();
        test_drain_pause();
        wait_drained();
        $display("covered %0d words: %0d allocs granted, %0d frees taken, %0d rejected",
                 words_seen, n_alloc_ok, n_free_ok, n_reject);
        $display("zone sizes 0 to 2047, idle and stall mixes, long output hold");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/bpa_pkg.sv
rtl/bpa_req_if.sv
rtl/bpa_rsp_if.sv
rtl/bpa_cfg_if.sv
rtl/bpa_ram.sv
rtl/buddy_page_allocator_unit.sv
rtl/bpa_checker.sv
tb/tb_buddy_page_allocator_unit.sv
